FILE: design/mi3_pkg.sv
package mi3_pkg;

  // Default word format: signed Q16.16.
  localparam int WORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF = 16;

  // Status that travels with a finished word.
  typedef struct packed {
    logic valid;
    logic singular;
  } ctl_t;

endpackage

FILE: design/mi3_adj.sv
module mi3_adj
  import mi3_pkg::*;
#(
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic signed [WORD_BITS-1:0]  a [9],
  output logic                         out_valid,
  output logic signed [WORD_BITS-1:0]  row [3],
  output logic signed [2*WORD_BITS:0]  adj [9]
);

  localparam int PW = 2 * WORD_BITS;
  localparam int CW = 2 * WORD_BITS + 1;

  // Each adjugate entry is p0*p1 - q0*q1 over these element indexes.
  localparam int PI [9] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
  localparam int PJ [9] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
  localparam int QI [9] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
  localparam int QJ [9] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

  logic                 valid_p;
  logic signed [PW-1:0] prod_p [9];
  logic signed [PW-1:0] prod_q [9];
  logic signed [WORD_BITS-1:0] row_p [3];

  // First stage: the eighteen element products.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_p <= 1'b0;
    end else begin
      valid_p <= in_valid;
    end
    for (int i = 0; i < 9; i++) begin
      prod_p[i] <= PW'(a[PI[i]]) * PW'(a[PJ[i]]);
      prod_q[i] <= PW'(a[QI[i]]) * PW'(a[QJ[i]]);
    end
    for (int j = 0; j < 3; j++) begin
      row_p[j] <= a[j];
    end
  end

  // Second stage: cofactor differences, already transposed.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= valid_p;
    end
    for (int i = 0; i < 9; i++) begin
      adj[i] <= CW'(prod_p[i]) - CW'(prod_q[i]);
    end
    for (int j = 0; j < 3; j++) begin
      row[j] <= row_p[j];
    end
  end

endmodule

FILE: design/mi3_det.sv
module mi3_det
  import mi3_pkg::*;
#(
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic signed [WORD_BITS-1:0]   row [3],
  input  logic signed [2*WORD_BITS:0]   adj_in [9],
  output logic                          out_valid,
  output logic signed [2*WORD_BITS:0]   adj [9],
  output logic signed [3*WORD_BITS+2:0] det
);

  localparam int PW = 2 * WORD_BITS;
  localparam int LW = 2 * WORD_BITS + 2;
  localparam int CW = 2 * WORD_BITS + 1;
  localparam int FW = 3 * WORD_BITS + 1;
  localparam int DW = 3 * WORD_BITS + 3;

  logic                 valid_c, valid_d;
  logic signed [LW-1:0] part_lo [3];
  logic signed [PW-1:0] part_hi [3];
  logic signed [FW-1:0] full [3];
  logic signed [CW-1:0] adj_c [9];
  logic signed [CW-1:0] adj_d [9];

  // The row-0 element times the cofactor is split at bit WORD_BITS+1 of the cofactor.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_c <= 1'b0;
    end else begin
      valid_c <= in_valid;
    end
    for (int j = 0; j < 3; j++) begin
      part_lo[j] <= LW'(row[j]) * LW'($signed({1'b0, adj_in[3*j][WORD_BITS:0]}));
      part_hi[j] <= PW'(row[j]) * PW'($signed(adj_in[3*j][CW-1:WORD_BITS+1]));
    end
    adj_c <= adj_in;
  end

  // Partial products are joined into full products.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_d <= 1'b0;
    end else begin
      valid_d <= valid_c;
    end
    for (int j = 0; j < 3; j++) begin
      full[j] <= (FW'(part_hi[j]) <<< (WORD_BITS + 1)) + FW'(part_lo[j]);
    end
    adj_d <= adj_c;
  end

  // The determinant is the sum of the three products.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= valid_d;
    end
    det <= DW'(full[0]) + DW'(full[1]) + DW'(full[2]);
    adj <= adj_d;
  end

endmodule

FILE: design/mi3_div.sv
module mi3_div
  import mi3_pkg::*;
#(
  parameter int WORD_BITS = WORD_BITS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic signed [2*WORD_BITS:0]   adj,
  input  logic signed [3*WORD_BITS+2:0] det,
  output ctl_t                          ctl,
  output logic signed [WORD_BITS-1:0]   b,
  output logic                          ovf
);

  localparam int W   = WORD_BITS;
  localparam int CW  = 2 * W + 1;
  localparam int DW  = 3 * W + 3;
  localparam int NA  = CW + 2 * FRAC_BITS + 1;
  localparam int NW  = ((NA > DW) ? NA : DW) + 1;
  localparam int XB  = DW + W + 2;
  localparam int XW  = (NW > XB) ? NW : XB;
  localparam int QW  = W + 1;
  localparam logic [QW-1:0] HALF = QW'(1) << (W - 1);
  localparam logic [W-1:0]  MAXP = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0]  MINN = {1'b1, {(W-1){1'b0}}};

  logic [CW-1:0] adj_mag;
  logic [DW-1:0] det_mag;

  ctl_t          ctl_q [0:W+2];
  logic          neg_q [0:W+2];
  logic          hi_q  [1:W+2];
  logic [XW-1:0] r_q   [0:W+1];
  logic [XW-1:0] d_q   [0:W+1];
  logic [QW-1:0] q_q   [1:W+2];
  logic [XW-1:0] dsh   [1:W+1];
  logic          ge    [1:W+1];

  logic [QW-1:0] mag;
  logic          sat_neg, sat_pos;

  assign adj_mag = adj[CW-1] ? CW'(-adj) : CW'(adj);
  assign det_mag = det[DW-1] ? DW'(-det) : DW'(det);

  // Rounded numerator 2|adj|*2^2F + |det| over denominator 2|det|.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_q[0] <= '0;
    end else begin
      ctl_q[0].valid    <= in_valid;
      ctl_q[0].singular <= (det == '0);
    end
    neg_q[0] <= adj[CW-1] ^ det[DW-1];
    r_q[0]   <= (XW'(adj_mag) << (2 * FRAC_BITS + 1)) + XW'(det_mag);
    d_q[0]   <= XW'(det_mag) << 1;
  end

  // A quotient that needs more than W+1 bits saturates in any case.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_q[1] <= '0;
    end else begin
      ctl_q[1] <= ctl_q[0];
    end
    neg_q[1] <= neg_q[0];
    hi_q[1]  <= r_q[0] >= (d_q[0] << QW);
    r_q[1]   <= r_q[0];
    d_q[1]   <= d_q[0];
    q_q[1]   <= '0;
  end

  // One restoring step per quotient bit, most significant first.
  for (genvar s = 1; s <= W + 1; s++) begin : g_step
    assign dsh[s] = d_q[s] << (W + 1 - s);
    assign ge[s]  = r_q[s] >= dsh[s];

    always_ff @(posedge clk) begin
      if (rst) begin
        ctl_q[s+1] <= '0;
      end else begin
        ctl_q[s+1] <= ctl_q[s];
      end
      neg_q[s+1] <= neg_q[s];
      hi_q[s+1]  <= hi_q[s];
      q_q[s+1]   <= q_q[s] | (ge[s] ? (QW'(1) << (W + 1 - s)) : '0);
    end

    if (s <= W) begin : g_rem
      always_ff @(posedge clk) begin
        r_q[s+1] <= ge[s] ? (r_q[s] - dsh[s]) : r_q[s];
        d_q[s+1] <= d_q[s];
      end
    end
  end

  // Sign, saturation and the singular case.
  assign mag     = q_q[W+2];
  assign sat_neg = hi_q[W+2] || (mag > HALF);
  assign sat_pos = hi_q[W+2] || (mag > HALF - QW'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else begin
      ctl <= ctl_q[W+2];
    end
    if (ctl_q[W+2].singular) begin
      b   <= '0;
      ovf <= 1'b0;
    end else if (neg_q[W+2]) begin
      b   <= sat_neg ? MINN : W'(-mag);
      ovf <= sat_neg;
    end else begin
      b   <= sat_pos ? MAXP : W'(mag);
      ovf <= sat_pos;
    end
  end

endmodule

FILE: design/matrix3x3_inverse.sv
// Channel  Direction  Handshake     Words
// command  in         start / busy  a00 .. a22, signed fixed point
// result   out        done          b00 .. b22, singular, overflow
//
// A new matrix is taken every cycle; busy is always low.
// The divider resolves one quotient bit per pipeline stage.
// Reset clears only the valid and singular bits; data registers are left as they are.
// The receiver cannot stall: each result shows on done for exactly one cycle.
module matrix3x3_inverse
  import mi3_pkg::*;
#(
  parameter int WORD_BITS = WORD_BITS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic signed [WORD_BITS-1:0] a00,
  input  logic signed [WORD_BITS-1:0] a01,
  input  logic signed [WORD_BITS-1:0] a02,
  input  logic signed [WORD_BITS-1:0] a10,
  input  logic signed [WORD_BITS-1:0] a11,
  input  logic signed [WORD_BITS-1:0] a12,
  input  logic signed [WORD_BITS-1:0] a20,
  input  logic signed [WORD_BITS-1:0] a21,
  input  logic signed [WORD_BITS-1:0] a22,
  output logic                        done,
  output logic signed [WORD_BITS-1:0] b00,
  output logic signed [WORD_BITS-1:0] b01,
  output logic signed [WORD_BITS-1:0] b02,
  output logic signed [WORD_BITS-1:0] b10,
  output logic signed [WORD_BITS-1:0] b11,
  output logic signed [WORD_BITS-1:0] b12,
  output logic signed [WORD_BITS-1:0] b20,
  output logic signed [WORD_BITS-1:0] b21,
  output logic signed [WORD_BITS-1:0] b22,
  output logic                        singular,
  output logic                        overflow
);

  logic signed [WORD_BITS-1:0]   a_in [9];
  logic signed [WORD_BITS-1:0]   row [3];
  logic signed [2*WORD_BITS:0]   adj_a [9];
  logic signed [2*WORD_BITS:0]   adj_d [9];
  logic signed [3*WORD_BITS+2:0] det;
  logic                          valid_a, valid_d;
  ctl_t                          ctl [9];
  logic signed [WORD_BITS-1:0]   b_out [9];
  logic [8:0]                    ovf;

  // The pipeline never holds off a command.
  assign busy = 1'b0;

  assign a_in[0] = a00;
  assign a_in[1] = a01;
  assign a_in[2] = a02;
  assign a_in[3] = a10;
  assign a_in[4] = a11;
  assign a_in[5] = a12;
  assign a_in[6] = a20;
  assign a_in[7] = a21;
  assign a_in[8] = a22;

  mi3_adj #(.WORD_BITS(WORD_BITS)) u_adj (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start),
    .a         (a_in),
    .out_valid (valid_a),
    .row       (row),
    .adj       (adj_a)
  );

  mi3_det #(.WORD_BITS(WORD_BITS)) u_det (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (valid_a),
    .row       (row),
    .adj_in    (adj_a),
    .out_valid (valid_d),
    .adj       (adj_d),
    .det       (det)
  );

  // One divider pipeline per element of the inverse.
  for (genvar i = 0; i < 9; i++) begin : g_div
    mi3_div #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_div (
      .clk      (clk),
      .rst      (rst),
      .in_valid (valid_d),
      .adj      (adj_d[i]),
      .det      (det),
      .ctl      (ctl[i]),
      .b        (b_out[i]),
      .ovf      (ovf[i])
    );
  end

  assign done     = ctl[0].valid;
  assign singular = ctl[0].singular;
  assign overflow = |ovf;

  assign b00 = b_out[0];
  assign b01 = b_out[1];
  assign b02 = b_out[2];
  assign b10 = b_out[3];
  assign b11 = b_out[4];
  assign b12 = b_out[5];
  assign b20 = b_out[6];
  assign b21 = b_out[7];
  assign b22 = b_out[8];

endmodule
